>>> rtl/core/vlasr_pkg.sv
// Package for the vector lane ALU with scan and reduce.
// Holds the lane width, op codes, sequencer states and divider handshake types.
// Has no dependencies; every other file of the block imports it.
package vlasr_pkg;

    localparam int LANE_W   = 32;
    localparam int OP_W     = 4;
    localparam int DIV_CNT_W = $clog2(LANE_W);

    localparam logic [OP_W-1:0] OP_ADD      = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB      = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL      = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV      = 4'd3;
    localparam logic [OP_W-1:0] OP_CMPGT    = 4'd4;
    localparam logic [OP_W-1:0] OP_SELECT   = 4'd5;
    localparam logic [OP_W-1:0] OP_SCAN_SUM = 4'd6;
    localparam logic [OP_W-1:0] OP_SCAN_MIN = 4'd9;
    localparam logic [OP_W-1:0] OP_RED_SUM  = 4'd10;
    localparam logic [OP_W-1:0] OP_RED_MIN  = 4'd13;

    typedef enum logic [1:0] {
        KIND_SUM  = 2'd0,
        KIND_PROD = 2'd1,
        KIND_MAX  = 2'd2,
        KIND_MIN  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

>>> rtl/core/vlasr_if.sv
// Valid/ready channel interfaces for the vector lane ALU.
// One carries an input lane beat, the other a result beat; both use vlasr_pkg.
interface vlasr_in_if import vlasr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [LANE_W-1:0] lane_a;
    logic signed [LANE_W-1:0] lane_b;
    logic [LANE_W-1:0]        lane_mask;
    logic                     last_lane;

    modport source (output valid, op, lane_a, lane_b, lane_mask, last_lane, input ready);
    modport sink (input valid, op, lane_a, lane_b, lane_mask, last_lane, output ready);
endinterface

interface vlasr_out_if import vlasr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [LANE_W-1:0] value;
    logic                     is_last;

    modport source (output valid, value, is_last, input ready);
    modport sink (input valid, value, is_last, output ready);
endinterface

>>> rtl/core/vector_lane_alu_scan_reduce.sv
// Top level of the vector lane ALU with scan and reduce.
// Uses vlasr_pkg, the channel interfaces in vlasr_if.sv and the divider vlasr_div.
//
// Usage: lane beats arrive on the lanes channel, one 32-bit signed lane each, with an
// op code, a select mask and a mark on the final lane of the vector. Result beats
// leave on the results channel with the lane value and a copy of the last-lane mark.
// Lane-wise ops give one result per lane. Scan ops give the running sum, product,
// max or min for every lane; reduce ops give only the total, at the last lane.
// Unused op codes give no result.
// Sequencing: one lane is taken at a time; the next is taken only after the current one
// has completed. A divide by a nonzero lane runs through the bit-serial divider at one
// quotient bit per cycle before the finish state; every other op goes straight there.
// In the finish state the result is written to the result register once that is free.
// Reset clears the running value and marks the next lane as the first of a vector.
// Stall: a finished result waits in the output register while the next lane is taken
// and worked on; a lane that gives a result completes only once that register is free.
module vector_lane_alu_scan_reduce
    import vlasr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    vlasr_in_if.sink   lanes,
    vlasr_out_if.source results
);

    state_t            state_reg, state_next;
    logic [OP_W-1:0]   op_reg;
    logic [LANE_W-1:0] a_reg, b_reg, m_reg;
    logic              last_reg;
    logic              neg_reg;
    logic [LANE_W-1:0] run_reg, run_next;
    logic              first_reg, first_next;
    logic              out_valid_reg, out_valid_next;
    logic [LANE_W-1:0] out_value_reg, out_value_next;
    logic              out_last_reg, out_last_next;

    logic              accept;
    logic              finish;
    logic              has_result;
    logic              is_accum;
    kind_t             kind;
    logic [LANE_W-1:0] result;
    logic [LANE_W-1:0] acc_new;
    logic [LANE_W-1:0] mul_x;
    logic [2*LANE_W-1:0] mul_full;
    logic [LANE_W-1:0] mag_a, mag_b;
    logic [LANE_W-1:0] quotient;
    div_ctl_t          div_ctl;
    div_sts_t          div_sts;

    assign accept = lanes.valid && lanes.ready;
    assign mag_a  = lanes.lane_a[LANE_W-1] ? LANE_W'(0) - lanes.lane_a : lanes.lane_a;
    assign mag_b  = lanes.lane_b[LANE_W-1] ? LANE_W'(0) - lanes.lane_b : lanes.lane_b;

    vlasr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (mag_a),
        .divisor  (mag_b),
        .sts      (div_sts),
        .quotient (quotient)
    );

    always_comb
    begin
        is_accum = op_reg inside {[OP_SCAN_SUM:OP_RED_MIN]};
        kind     = kind_t'(2'(op_reg - OP_SCAN_SUM));
        mul_x    = (is_accum && kind == KIND_PROD) ? run_reg : b_reg;
        mul_full = a_reg * mul_x;
        acc_new  = a_reg;
        if (!first_reg)
        begin
            case (kind)
                KIND_SUM:  acc_new = run_reg + a_reg;
                KIND_PROD: acc_new = mul_full[LANE_W-1:0];
                KIND_MAX:  acc_new = ($signed(a_reg) > $signed(run_reg)) ? a_reg : run_reg;
                KIND_MIN:  acc_new = ($signed(run_reg) > $signed(a_reg)) ? a_reg : run_reg;
                default:   acc_new = a_reg;
            endcase
        end
        has_result = 1'b1;
        result     = acc_new;
        case (op_reg)
            OP_ADD:    result = a_reg + b_reg;
            OP_SUB:    result = a_reg - b_reg;
            OP_MUL:    result = mul_full[LANE_W-1:0];
            OP_DIV:    result = (b_reg == '0) ? a_reg :
                                neg_reg ? LANE_W'(0) - quotient : quotient;
            OP_CMPGT:  result = ($signed(a_reg) > $signed(b_reg)) ? '1 : '0;
            OP_SELECT: result = (a_reg & m_reg) | (b_reg & ~m_reg);
            default:
            begin
                if (!is_accum)
                begin
                    has_result = 1'b0;
                end
                else if (op_reg >= OP_RED_SUM && !last_reg)
                begin
                    has_result = 1'b0;
                end
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (lanes.op == OP_DIV && lanes.lane_b != '0) ?
                                 ST_DIVIDE : ST_FINISH;
                end
            end
            ST_DIVIDE:
            begin
                if (div_sts.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath updates.
    always_comb
    begin
        lanes.ready    = (state_reg == ST_IDLE);
        div_ctl.start  = (state_reg == ST_IDLE) && lanes.valid &&
                         lanes.op == OP_DIV && lanes.lane_b != '0;
        finish         = (state_reg == ST_FINISH) &&
                         (!has_result || !out_valid_reg || results.ready);
        run_next       = run_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        if (finish)
        begin
            first_next = last_reg;
            if (is_accum)
            begin
                run_next = acc_new;
            end
            if (has_result)
            begin
                out_valid_next = 1'b1;
                out_value_next = result;
                out_last_next  = last_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_reg       <= '0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= lanes.op;
            a_reg    <= lanes.lane_a;
            b_reg    <= lanes.lane_b;
            m_reg    <= lanes.lane_mask;
            last_reg <= lanes.last_lane;
            neg_reg  <= lanes.lane_a[LANE_W-1] ^ lanes.lane_b[LANE_W-1];
        end
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign results.valid   = out_valid_reg;
    assign results.value   = out_value_reg;
    assign results.is_last = out_last_reg;

    a_divide_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIVIDE |-> div_sts.busy || div_sts.done)
        else $error("sequencer waits on a divider that is not running");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("accepted lane did not start work");

    a_running_only_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(run_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("running value changed outside lane completion");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result beat raised without a completed lane");

endmodule

>>> rtl/core/vlasr_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Used by the vector lane ALU for its signed divide; depends on vlasr_pkg.
module vlasr_div
    import vlasr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  div_ctl_t          ctl,
    input  logic [LANE_W-1:0] dividend,
    input  logic [LANE_W-1:0] divisor,
    output div_sts_t          sts,
    output logic [LANE_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [LANE_W-1:0]    rem_reg, rem_next;
    logic [LANE_W-1:0]    quo_reg, quo_next;
    logic [LANE_W-1:0]    den_reg, den_next;
    logic [LANE_W:0]      shifted;
    logic [LANE_W:0]      trial;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[LANE_W-1]};
        trial     = shifted - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(LANE_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = trial[LANE_W] ? shifted[LANE_W-1:0] : trial[LANE_W-1:0];
            quo_next = {quo_reg[LANE_W-2:0], ~trial[LANE_W]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = quo_reg;

endmodule
